// ===== sv/mlfq_pkg.sv =====
// shared types, constants and fixed point helpers for the mlfq scheduler math block
// used by mlfq_div and mlfq_fixed_point_scheduler_math; no dependencies
package mlfq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int WORD_W    = 32;
  localparam int DVD_W     = WORD_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(DVD_W + 1);

  localparam int READY_W   = 7;
  localparam int NICE_W    = 6;
  localparam int PRIO_W    = 6;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 104;

  localparam int PRI_MAX   = 63;
  localparam int PRI_MIN   = 0;
  localparam int MAX_READY = 64;

  localparam longint FX_ONE_L = 64'sd1 << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] FX_ONE   = WORD_W'(FX_ONE_L);
  localparam logic signed [WORD_W-1:0] FX_HALF  = WORD_W'(FX_ONE_L / 2);
  localparam logic signed [WORD_W-1:0] LOAD_C1  =
    WORD_W'((59 * FX_ONE_L * FX_ONE_L) / (60 * FX_ONE_L));
  localparam logic signed [WORD_W-1:0] LOAD_C2  =
    WORD_W'((FX_ONE_L * FX_ONE_L) / (60 * FX_ONE_L));
  localparam logic signed [WORD_W-1:0] PRI_BASE = WORD_W'(PRI_MAX * FX_ONE_L);
  localparam logic signed [WORD_W-1:0] X100     = WORD_W'(100);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RECENT = 2'd1,
    REQ_PRIO   = 2'd2
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LD_C1,
    ST_LD_C2,
    ST_LD_SUM,
    ST_RC_DIV,
    ST_RC_MUL,
    ST_RC_SUM,
    ST_PR_SUB,
    ST_PR_RND,
    ST_X100_L,
    ST_X100_C,
    ST_X100_END,
    ST_DONE
  } state_e;

  // product divided by one, truncated toward zero, wrapped to a word
  function automatic logic signed [WORD_W-1:0] fx_trunc(input logic signed [2*WORD_W-1:0] p);
    logic signed [2*WORD_W-1:0] adj;
    adj = p[2*WORD_W-1] ? p + (2*WORD_W)'(FX_ONE_L - 1) : p;
    return adj[FRAC_BITS+WORD_W-1:FRAC_BITS];
  endfunction

  // round to nearest integer, half away from zero, with wrapping sums
  function automatic logic signed [WORD_W-1:0] fx_nearest(input logic signed [WORD_W-1:0] x);
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] adj;
    y   = x[WORD_W-1] ? x - FX_HALF : x + FX_HALF;
    adj = y[WORD_W-1] ? y + (FX_ONE - WORD_W'(1)) : y;
    return adj >>> FRAC_BITS;
  endfunction

endpackage

// ===== sv/mlfq_fixed_point_scheduler_math.sv =====
// top level of the mlfq scheduler math block, 17.14 signed fixed point
// depends on mlfq_pkg and mlfq_div
//
// One item is worked at a time by a small sequencer around one shared 32x32 multiplier
// and an iterative divider. s_axis_tready is high only while the sequencer is idle. A cpu
// usage update of a thread that is not idle waits on the one bit per cycle divider that
// forms 2L/(2L+1); when 2L+1 wraps to zero the divider is skipped. The result waits in an
// output register, so the sequencer is ready for the next item in the cycle after the
// result is loaded, while it may still be unclaimed. A new result waits in the sequencer
// while the output register stays full. The load average clears at reset.
module mlfq_fixed_point_scheduler_math (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // ready_count, running_not_idle, thread_is_idle, cpu_usage, niceness, zero fill
  input  logic [mlfq_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // req_type
  input  logic [1:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // cpu_usage_out, thread_priority, load_x100, cpu_usage_x100, zero fill
  output logic [mlfq_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // skipped
  output logic                                 m_axis_tuser
);

  localparam int W = mlfq_pkg::WORD_W;

  mlfq_pkg::state_e state_q, state_d;

  logic signed [W-1:0]                 load_q, load_d;
  logic                                m_valid_q, m_valid_d;

  mlfq_pkg::req_e                      req_q;
  logic [mlfq_pkg::READY_W-1:0]        ready_q;
  logic                                run_q;
  logic                                idle_q;
  logic signed [W-1:0]                 cpu_q;
  logic signed [mlfq_pkg::NICE_W-1:0]  nice_q;

  logic signed [W-1:0]                 cpu_out_q;
  logic [mlfq_pkg::PRIO_W-1:0]         prio_q;
  logic                                skip_q;
  logic signed [W-1:0]                 tmp_q;
  logic signed [W-1:0]                 k_q;
  logic                                neg_q;
  logic signed [W-1:0]                 load100_q;
  logic signed [W-1:0]                 cpu100_q;
  logic signed [2*W-1:0]               prod_q;
  logic [mlfq_pkg::OUT_DATA_W-1:0]     out_data_q;
  logic                                out_skip_q;

  logic signed [W-1:0]                 mul_a;
  logic signed [W-1:0]                 mul_b;
  logic                                div_start;
  logic                                out_load;
  logic                                accept;

  logic [mlfq_pkg::READY_W-1:0]        ready_sat;
  logic [mlfq_pkg::READY_W-1:0]        n_run;
  logic signed [W-1:0]                 twol;
  logic signed [W-1:0]                 den;
  logic [W-1:0]                        twol_mag;
  logic [W-1:0]                        den_mag;
  logic signed [W-1:0]                 nice_ext;
  logic signed [W-1:0]                 cpu_div4;
  logic signed [W-1:0]                 prio_raw;
  logic signed [W-1:0]                 prio_rnd;
  logic signed [W-1:0]                 prio_clamp;
  logic                                div_done;
  logic [mlfq_pkg::DVD_W-1:0]          div_quo;
  logic [mlfq_pkg::DVD_W-1:0]          quo_fix;

  mlfq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({twol_mag, {mlfq_pkg::FRAC_BITS{1'b0}}}),
    .divisor_i  (den_mag),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ready_sat = (ready_q > mlfq_pkg::READY_W'(mlfq_pkg::MAX_READY))
              ? mlfq_pkg::READY_W'(mlfq_pkg::MAX_READY) : ready_q;
    n_run     = ready_sat + mlfq_pkg::READY_W'(run_q);
    twol      = load_q <<< 1;
    den       = twol + mlfq_pkg::FX_ONE;
    twol_mag  = twol[W-1] ? W'(-twol) : W'(twol);
    den_mag   = den[W-1] ? W'(-den) : W'(den);
    quo_fix   = neg_q ? -div_quo : div_quo;
    nice_ext  = {{(W-mlfq_pkg::NICE_W){nice_q[mlfq_pkg::NICE_W-1]}}, nice_q};
    cpu_div4  = (cpu_q[W-1] ? cpu_q + W'(3) : cpu_q) >>> 2;
    prio_raw  = mlfq_pkg::PRI_BASE - cpu_div4 - (nice_ext <<< (mlfq_pkg::FRAC_BITS + 1));
    prio_rnd  = mlfq_pkg::fx_nearest(tmp_q);
    if (prio_rnd > mlfq_pkg::PRI_MAX) begin
      prio_clamp = W'(mlfq_pkg::PRI_MAX);
    end else if (prio_rnd < mlfq_pkg::PRI_MIN) begin
      prio_clamp = W'(mlfq_pkg::PRI_MIN);
    end else begin
      prio_clamp = prio_rnd;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlfq_pkg::ST_IDLE: begin
        if (accept) state_d = mlfq_pkg::ST_DISPATCH;
      end
      mlfq_pkg::ST_DISPATCH: begin
        case (req_q)
          mlfq_pkg::REQ_LOAD:   state_d = mlfq_pkg::ST_LD_C1;
          mlfq_pkg::REQ_RECENT: begin
            if (idle_q) state_d = mlfq_pkg::ST_X100_L;
            else if (den == '0) state_d = mlfq_pkg::ST_RC_MUL;
            else state_d = mlfq_pkg::ST_RC_DIV;
          end
          mlfq_pkg::REQ_PRIO:   state_d = idle_q ? mlfq_pkg::ST_X100_L : mlfq_pkg::ST_PR_SUB;
          default:              state_d = mlfq_pkg::ST_X100_L;
        endcase
      end
      mlfq_pkg::ST_LD_C1:    state_d = mlfq_pkg::ST_LD_C2;
      mlfq_pkg::ST_LD_C2:    state_d = mlfq_pkg::ST_LD_SUM;
      mlfq_pkg::ST_LD_SUM:   state_d = mlfq_pkg::ST_X100_L;
      mlfq_pkg::ST_RC_DIV: begin
        if (div_done) state_d = mlfq_pkg::ST_RC_MUL;
      end
      mlfq_pkg::ST_RC_MUL:   state_d = mlfq_pkg::ST_RC_SUM;
      mlfq_pkg::ST_RC_SUM:   state_d = mlfq_pkg::ST_X100_L;
      mlfq_pkg::ST_PR_SUB:   state_d = mlfq_pkg::ST_PR_RND;
      mlfq_pkg::ST_PR_RND:   state_d = mlfq_pkg::ST_X100_L;
      mlfq_pkg::ST_X100_L:   state_d = mlfq_pkg::ST_X100_C;
      mlfq_pkg::ST_X100_C:   state_d = mlfq_pkg::ST_X100_END;
      mlfq_pkg::ST_X100_END: state_d = mlfq_pkg::ST_DONE;
      mlfq_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) state_d = mlfq_pkg::ST_IDLE;
      end
      default:               state_d = mlfq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    mul_a         = load_q;
    mul_b         = mlfq_pkg::X100;
    unique case (state_q)
      mlfq_pkg::ST_IDLE:     s_axis_tready = 1'b1;
      mlfq_pkg::ST_DISPATCH: begin
        div_start = (req_q == mlfq_pkg::REQ_RECENT) && !idle_q && (den != '0);
      end
      mlfq_pkg::ST_LD_C1: begin
        mul_a = mlfq_pkg::LOAD_C1;
        mul_b = load_q;
      end
      mlfq_pkg::ST_LD_C2: begin
        mul_a = mlfq_pkg::LOAD_C2;
        mul_b = W'(n_run);
      end
      mlfq_pkg::ST_RC_MUL: begin
        mul_a = k_q;
        mul_b = cpu_q;
      end
      mlfq_pkg::ST_X100_C: begin
        mul_a = cpu_out_q;
        mul_b = mlfq_pkg::X100;
      end
      mlfq_pkg::ST_DONE:     out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    load_d    = load_q;
    m_valid_d = m_valid_q;
    if (state_q == mlfq_pkg::ST_LD_SUM) load_d = tmp_q + prod_q[W-1:0];
    if (out_load) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mlfq_pkg::ST_IDLE;
      load_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      load_q    <= load_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      mlfq_pkg::ST_IDLE: begin
        if (accept) begin
          req_q     <= mlfq_pkg::req_e'(s_axis_tuser);
          ready_q   <= s_axis_tdata[6:0];
          run_q     <= s_axis_tdata[7];
          idle_q    <= s_axis_tdata[8];
          cpu_q     <= s_axis_tdata[40:9];
          nice_q    <= s_axis_tdata[46:41];
          cpu_out_q <= s_axis_tdata[40:9];
          prio_q    <= '0;
          skip_q    <= 1'b0;
        end
      end
      mlfq_pkg::ST_DISPATCH: begin
        skip_q <= idle_q && (req_q == mlfq_pkg::REQ_RECENT || req_q == mlfq_pkg::REQ_PRIO);
        neg_q  <= twol[W-1] ^ den[W-1];
        k_q    <= '0;
      end
      mlfq_pkg::ST_LD_C2:    tmp_q <= mlfq_pkg::fx_trunc(prod_q);
      mlfq_pkg::ST_RC_DIV: begin
        if (div_done) k_q <= quo_fix[W-1:0];
      end
      mlfq_pkg::ST_RC_SUM: begin
        cpu_out_q <= mlfq_pkg::fx_trunc(prod_q) + (nice_ext <<< mlfq_pkg::FRAC_BITS);
      end
      mlfq_pkg::ST_PR_SUB:   tmp_q <= prio_raw;
      mlfq_pkg::ST_PR_RND:   prio_q <= prio_clamp[mlfq_pkg::PRIO_W-1:0];
      mlfq_pkg::ST_X100_C:   load100_q <= mlfq_pkg::fx_nearest(prod_q[W-1:0]);
      mlfq_pkg::ST_X100_END: cpu100_q <= mlfq_pkg::fx_nearest(prod_q[W-1:0]);
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= {2'b00, cpu100_q, load100_q, prio_q, cpu_out_q};
      out_skip_q <= skip_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_skip_q;

endmodule

// ===== sv/mlfq_div.sv =====
// iterative unsigned restoring divider, one quotient bit per cycle
// depends on mlfq_pkg for widths
module mlfq_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [mlfq_pkg::DVD_W-1:0]           dividend_i,
  input  logic [mlfq_pkg::WORD_W-1:0]          divisor_i,
  output logic                                 done_o,
  output logic [mlfq_pkg::DVD_W-1:0]           quotient_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [mlfq_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [mlfq_pkg::WORD_W:0]          rem_q, rem_d;
  logic [mlfq_pkg::DVD_W-1:0]         quo_q, quo_d;
  logic [mlfq_pkg::WORD_W-1:0]        dsr_q, dsr_d;
  logic [mlfq_pkg::WORD_W:0]          rem_sh;
  logic [mlfq_pkg::WORD_W:0]          rem_sub;

  always_comb begin
    rem_sh  = {rem_q[mlfq_pkg::WORD_W-1:0], quo_q[mlfq_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = mlfq_pkg::CNT_W'(mlfq_pkg::DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!rem_sub[mlfq_pkg::WORD_W]) begin
        rem_d = rem_sub;
        quo_d = {quo_q[mlfq_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[mlfq_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - mlfq_pkg::CNT_W'(1);
      if (cnt_q == mlfq_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
